// File: sv/tsf_pkg.sv
`timescale 1ns / 1ps

package tsf_pkg;

	localparam int SAMPLES_PER_BURST = 10;
	localparam int SAMPLE_BITS       = 12;
	localparam int GAIN_FRAC_BITS    = 14;
	localparam int LIMIT_BITS        = 12;
	localparam int CAL_BITS          = 16;
	localparam int COORD_BITS        = 16;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;

	// store address, scan step (0 = pivot read, 1..N = partner reads), neighbor count
	localparam int ADDR_W = $clog2(SAMPLES_PER_BURST);
	localparam int STEP_W = $clog2(SAMPLES_PER_BURST + 1);
	localparam int CNT_W  = $clog2(SAMPLES_PER_BURST);

	typedef logic [SAMPLE_BITS-1:0]       sample_t;
	typedef logic [LIMIT_BITS-1:0]        limit_t;
	typedef logic signed [CAL_BITS-1:0]   cal_word_t;
	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic [ADDR_W-1:0]            addr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLUSTER_RADIUS,
		REG_AGREE_LIMIT,
		REG_X_GAIN,
		REG_X_OFFSET,
		REG_Y_GAIN,
		REG_Y_OFFSET
	} cfg_reg_t;

	typedef struct packed {
		limit_t    cluster_radius;
		limit_t    agree_limit;
		cal_word_t x_gain;
		cal_word_t x_offset;
		cal_word_t y_gain;
		cal_word_t y_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cluster_radius: limit_t'(50),
		agree_limit:    limit_t'(50),
		x_gain:         cal_word_t'(16384),
		x_offset:       cal_word_t'(0),
		y_gain:         cal_word_t'(16384),
		y_offset:       cal_word_t'(0)
	};

	typedef struct packed {
		sample_t x;
		sample_t y;
	} sample_pair_t;

	typedef struct packed {
		sample_pair_t first;
		sample_pair_t second;
	} cal_req_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		logic   rejected;
	} cal_res_t;

	function automatic sample_t abs_diff(input sample_t a, input sample_t b);
		return (a > b) ? sample_t'(a - b) : sample_t'(b - a);
	endfunction

endpackage

// File: sv/tsf_sample_if.sv
`timescale 1ns / 1ps

interface tsf_sample_if;
	import tsf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t x_sample;
	sample_t y_sample;

	modport source (output valid, output x_sample, output y_sample, input ready);
	modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

// File: sv/tsf_coord_if.sv
`timescale 1ns / 1ps

interface tsf_coord_if;
	import tsf_pkg::*;

	logic   valid;
	logic   ready;
	coord_t coord_x;
	coord_t coord_y;
	logic   rejected;

	modport source (output valid, output coord_x, output coord_y, output rejected,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input rejected,
		output ready);
endinterface

// File: sv/tsf_cfg_if.sv
`timescale 1ns / 1ps

interface tsf_cfg_if;
	import tsf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/tsf_store.sv
`timescale 1ns / 1ps

module tsf_store (
	input  logic                 clk,
	input  logic                 we,
	input  tsf_pkg::addr_t       waddr,
	input  tsf_pkg::sample_pair_t wdata,
	input  tsf_pkg::addr_t       raddr,
	output tsf_pkg::sample_pair_t rdata
);
	import tsf_pkg::*;

	sample_pair_t mem_q [SAMPLES_PER_BURST];
	sample_pair_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/tsf_scan.sv
`timescale 1ns / 1ps

module tsf_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  tsf_pkg::limit_t       radius,
	output tsf_pkg::addr_t        rd_addr,
	input  tsf_pkg::sample_pair_t rd_data,
	output logic                  done,
	output tsf_pkg::sample_pair_t pick
);
	import tsf_pkg::*;

	localparam int LANES = 2;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

	// travels alongside the registered store read
	typedef struct packed {
		logic valid;
		logic pivot;
		logic self_ref;
		logic row_end;
		logic first_row;
		logic scan_end;
	} tag_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	addr_t               row_q;
	tag_t                tag_s1;
	tag_t                issue;
	logic                done_q;
	addr_t               partner;

	sample_t             lane_data [LANES];
	sample_t             pivot_q   [LANES];
	sample_t             pick_q    [LANES];
	logic [CNT_W-1:0]    cnt_q     [LANES];
	logic [CNT_W-1:0]    best_q    [LANES];
	logic [CNT_W-1:0]    cnt_nxt   [LANES];
	logic                hit       [LANES];

	assign partner = addr_t'(step_q - 1'b1);
	assign rd_addr = (step_q == '0) ? row_q : partner;

	always_comb begin
		issue.valid     = (state_q == S_RUN);
		issue.pivot     = (step_q == '0);
		issue.self_ref  = (step_q != '0) && (partner == row_q);
		issue.row_end   = (step_q == STEP_W'(SAMPLES_PER_BURST));
		issue.first_row = (row_q == '0);
		issue.scan_end  = issue.row_end && (row_q == addr_t'(SAMPLES_PER_BURST - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			row_q   <= '0;
			tag_s1  <= '0;
			done_q  <= 1'b0;
		end else begin
			tag_s1 <= issue;
			done_q <= tag_s1.valid && tag_s1.scan_end;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						step_q  <= '0;
						row_q   <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (issue.row_end) begin
						step_q <= '0;
						if (issue.scan_end) begin
							state_q <= S_DRAIN;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (done_q) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign lane_data[0] = rd_data.x;
	assign lane_data[1] = rd_data.y;

	// one distance compare per axis, one partner per cycle
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			hit[l]     = !tag_s1.self_ref && (abs_diff(lane_data[l], pivot_q[l]) < radius);
			cnt_nxt[l] = cnt_q[l] + CNT_W'(hit[l]);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (tag_s1.valid) begin
				if (tag_s1.pivot) begin
					pivot_q[l] <= lane_data[l];
					cnt_q[l]   <= '0;
					if (tag_s1.first_row) begin
						pick_q[l] <= lane_data[l];
						best_q[l] <= '0;
					end
				end else begin
					cnt_q[l] <= cnt_nxt[l];
					// strictly greater: earliest sample wins a tie
					if (tag_s1.row_end && (cnt_nxt[l] > best_q[l])) begin
						best_q[l] <= cnt_nxt[l];
						pick_q[l] <= pivot_q[l];
					end
				end
			end
		end
	end

	assign done   = done_q;
	assign pick.x = pick_q[0];
	assign pick.y = pick_q[1];

endmodule

// File: sv/tsf_calib.sv
`timescale 1ns / 1ps

module tsf_calib (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tsf_pkg::cal_req_t req,
	input  tsf_pkg::cfg_t     cfg,
	output logic              done,
	output tsf_pkg::cal_res_t res
);
	import tsf_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + 1 + CAL_BITS;
	localparam int SUM_W  = PROD_W + 1;

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_MUL, S_ADD} state_t;

	state_t                    state_q;
	logic                      axis_q;
	logic                      done_q;
	cal_res_t                  res_q;
	cal_req_t                  req_q;
	sample_t                   raw_x_q;
	sample_t                   raw_y_q;
	logic signed [PROD_W-1:0]  prod_s1;

	logic signed [SAMPLE_BITS:0] mul_a;
	cal_word_t                   mul_b;
	cal_word_t                   offset;
	logic signed [PROD_W-1:0]    mul_p;
	logic signed [PROD_W-1:0]    floored;
	logic signed [SUM_W-1:0]     sum;
	coord_t                      clamped;
	logic                        reject;

	// one multiplier, X then Y
	assign mul_a   = $signed({1'b0, (axis_q ? raw_y_q : raw_x_q)});
	assign mul_b   = axis_q ? cfg.y_gain : cfg.x_gain;
	assign offset  = axis_q ? cfg.y_offset : cfg.x_offset;
	assign mul_p   = mul_a * mul_b;
	assign floored = prod_s1 >>> GAIN_FRAC_BITS;
	assign sum     = SUM_W'(floored) + SUM_W'(offset);

	always_comb begin
		if (sum[SUM_W-1]) begin
			clamped = '0;
		end else if (|sum[SUM_W-2:COORD_BITS]) begin
			clamped = '1;
		end else begin
			clamped = sum[COORD_BITS-1:0];
		end
	end

	assign reject = (abs_diff(req_q.first.x, req_q.second.x) > cfg.agree_limit)
		|| (abs_diff(req_q.first.y, req_q.second.y) > cfg.agree_limit);

	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
		end
		if (state_q == S_CHECK) begin
			raw_x_q <= sample_t'(req_q.first.x >> 1) + sample_t'(req_q.second.x >> 1);
			raw_y_q <= sample_t'(req_q.first.y >> 1) + sample_t'(req_q.second.y >> 1);
		end
		prod_s1 <= mul_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					axis_q <= 1'b0;
					if (reject) begin
						res_q   <= '{coord_x: '0, coord_y: '0, rejected: 1'b1};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						res_q.rejected <= 1'b0;
						state_q        <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (axis_q) begin
						res_q.coord_y <= clamped;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						res_q.coord_x <= clamped;
						axis_q        <= 1'b1;
						state_q       <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: sv/touch_sample_cluster_filter_top.sv
// Touch sample cluster filter. Raw converter pairs arrive on the samples channel in two
// bursts of SAMPLES_PER_BURST beats. A beat that does not close a burst leaves the block
// ready for the next one. The beat that closes a burst starts a pairwise scan: every
// stored sample is compared with every other one through the store's single read port,
// one pair per axis per cycle, each sample read once as pivot and then all N as partners.
// After the closing beat of a first burst the block stays not ready until the scan is
// done. For each axis the sample with the most neighbors closer than cluster_radius is
// kept; ties go to the earliest, and a burst with no neighbors at all keeps its first
// sample. After the second burst the two picks are checked against agree_limit, then
// each axis is averaged and calibrated as floor(raw * gain / 2^GAIN_FRAC_BITS) + offset,
// clamped to 0..65535, on one shared multiplier, in a multiply step and an add step per
// axis. The closing beat of a second burst leaves the block not ready through the scan,
// the check and the calibration (no calibration on a reject), and for as long as it
// waits for the output register to be taken. One coords beat follows every second burst;
// a disagreeing pair gives rejected = 1 with zero coordinates. The result sits in an
// output register, so the next burst can start while it waits to be taken. cfg writes
// are taken at any time, one per cycle; indexes beyond y_offset are ignored.
`timescale 1ns / 1ps

module touch_sample_cluster_filter_top (
	input  logic         clk,
	input  logic         arst_n,
	tsf_sample_if.sink   samples,
	tsf_coord_if.source  coords,
	tsf_cfg_if.sink      cfg
);
	import tsf_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CAL, S_OUT} state_t;

	state_t       state_q;
	cfg_t         cfg_q;
	addr_t        pos_q;      // write slot within the burst
	logic         burst_q;    // 0: first burst, 1: second burst
	sample_pair_t first_q;    // picks of the first burst
	logic         out_valid_q;
	cal_res_t     out_q;

	logic         accept;
	logic         burst_end;
	logic         scan_done;
	sample_pair_t scan_pick;
	addr_t        rd_addr;
	sample_pair_t rd_data;
	logic         cal_start;
	logic         cal_done;
	cal_req_t     cal_req;
	cal_res_t     cal_res;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CLUSTER_RADIUS: cfg_q.cluster_radius <= cfg.data[LIMIT_BITS-1:0];
				REG_AGREE_LIMIT:    cfg_q.agree_limit    <= cfg.data[LIMIT_BITS-1:0];
				REG_X_GAIN:         cfg_q.x_gain         <= cal_word_t'(cfg.data);
				REG_X_OFFSET:       cfg_q.x_offset       <= cal_word_t'(cfg.data);
				REG_Y_GAIN:         cfg_q.y_gain         <= cal_word_t'(cfg.data);
				REG_Y_OFFSET:       cfg_q.y_offset       <= cal_word_t'(cfg.data);
				default: ;
			endcase
		end
	end

	// input side
	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign burst_end     = accept && (pos_q == addr_t'(SAMPLES_PER_BURST - 1));

	tsf_store u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (pos_q),
		.wdata ('{x: samples.x_sample, y: samples.y_sample}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tsf_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (burst_end),
		.radius  (cfg_q.cluster_radius),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (scan_done),
		.pick    (scan_pick)
	);

	assign cal_start = (state_q == S_SCAN) && scan_done && burst_q;
	assign cal_req   = '{first: first_q, second: scan_pick};

	tsf_calib u_calib (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cal_start),
		.req    (cal_req),
		.cfg    (cfg_q),
		.done   (cal_done),
		.res    (cal_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			burst_q     <= 1'b0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (coords.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (burst_end) begin
							pos_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						burst_q <= !burst_q;
						if (burst_q) begin
							state_q <= S_CAL;
						end else begin
							first_q <= scan_pick;
							state_q <= S_IDLE;
						end
					end
				end
				S_CAL: begin
					if (cal_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// wait for the output register to free up
					if (!out_valid_q || coords.ready) begin
						out_q       <= cal_res;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign coords.valid    = out_valid_q;
	assign coords.coord_x  = out_q.coord_x;
	assign coords.coord_y  = out_q.coord_y;
	assign coords.rejected = out_q.rejected;

endmodule

// File: sv/tsf_checker.sv
`timescale 1ns / 1ps

module tsf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input tsf_pkg::coord_t    coord_x,
	input tsf_pkg::coord_t    coord_y,
	input logic               rejected
);
	import tsf_pkg::*;

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("coords beat dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(coord_x) && $stable(coord_y) && $stable(rejected))
		else $error("coords payload changed while stalled");

	// a reject carries zero coordinates
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> (coord_x == '0) && (coord_y == '0))
		else $error("rejected beat with nonzero coordinates");

	// no result rises right after an accepted sample beat
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after a sample beat");

endmodule

bind touch_sample_cluster_filter_top tsf_checker u_tsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (coords.valid),
	.out_ready (coords.ready),
	.coord_x   (coords.coord_x),
	.coord_y   (coords.coord_y),
	.rejected  (coords.rejected)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

// Touch sample filter testbench.
// Sample pairs go in on the samples channel and the predictor below follows
// every accepted beat. Every twentieth beat closes a burst pair, and the
// predictor then queues the coords beat it expects. The checker pops that
// queue on each coords beat and compares x, y and the reject flag.
// Register writes only go in while the block is quiet: the queue must be
// empty, and then we wait out a full scan, because a first-burst scan
// gives no result to wait for.
module tb;
	import tsf_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int PAIR_BEATS  = 2 * SAMPLES_PER_BURST;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	// pairwise scan, agree check and calibration after a closing beat, plus slack
	localparam int SETTLE_CYCLES = SAMPLES_PER_BURST * (SAMPLES_PER_BURST + 1) + 3 + 5 + 40;
	localparam int MAX_REPORTS   = 10;
	localparam cal_word_t UNITY_GAIN = cal_word_t'(1 << GAIN_FRAC_BITS);
	// register indexes past y_offset; the block must drop writes to them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 7;

	typedef sample_t burst_t [SAMPLES_PER_BURST];

	logic clk;
	logic arst_n;

	tsf_sample_if samples_if ();
	tsf_coord_if  coords_if ();
	tsf_cfg_if    cfg_if ();

	touch_sample_cluster_filter_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.coords  (coords_if),
		.cfg     (cfg_if)
	);

	// predicted filter state
	cfg_t        regs_model = CFG_RESET;
	burst_t      x_hist;
	burst_t      y_hist;
	int unsigned burst_beat = 0;
	sample_t     first_pick_x = '0;
	sample_t     first_pick_y = '0;
	cal_res_t    coords_due [$];

	// traffic shaping, shared with the coords process
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned coords_hold    = 0;
	int unsigned fault_count    = 0;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// hard stop if the block hangs or drops a result
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic sample_t sample_dist(input sample_t a, input sample_t b);
		return (a > b) ? sample_t'(a - b) : sample_t'(b - a);
	endfunction

	// sample with the most neighbors strictly inside the radius; a tie keeps the
	// earlier one, and with no neighbors at all the first beat stays
	function automatic sample_t densest_sample(input burst_t vals);
		int      best;
		int      hits;
		sample_t pick;
		best = 0;
		pick = vals[0];
		for (int i = 0; i < SAMPLES_PER_BURST; i++) begin
			hits = 0;
			for (int j = 0; j < SAMPLES_PER_BURST; j++) begin
				if (i != j && sample_dist(vals[i], vals[j]) < regs_model.cluster_radius)
					hits++;
			end
			if (hits > best) begin
				best = hits;
				pick = vals[i];
			end
		end
		return pick;
	endfunction

	// floor(raw * gain / 2^frac) + offset, clamped to the coordinate range
	function automatic coord_t calibrate_axis(input logic [SAMPLE_BITS:0] raw,
		input cal_word_t gain, input cal_word_t offset);
		longint scaled;
		scaled = (longint'(raw) * longint'(gain)) >>> GAIN_FRAC_BITS;
		scaled += longint'(offset);
		if (scaled < 0)
			return '0;
		if (scaled > longint'((1 << COORD_BITS) - 1))
			return '1;
		return coord_t'(scaled);
	endfunction

	// one accepted sample beat; queues a coords beat when a burst pair closes
	function automatic void cluster_filter_step(input sample_t xs, input sample_t ys);
		sample_t              sx;
		sample_t              sy;
		logic [SAMPLE_BITS:0] mean_x;
		logic [SAMPLE_BITS:0] mean_y;
		cal_res_t             res;
		x_hist[burst_beat % SAMPLES_PER_BURST] = xs;
		y_hist[burst_beat % SAMPLES_PER_BURST] = ys;
		burst_beat++;
		if (burst_beat == SAMPLES_PER_BURST) begin
			first_pick_x = densest_sample(x_hist);
			first_pick_y = densest_sample(y_hist);
		end else if (burst_beat == PAIR_BEATS) begin
			burst_beat = 0;
			sx = densest_sample(x_hist);
			sy = densest_sample(y_hist);
			res = '0;
			if (sample_dist(first_pick_x, sx) > regs_model.agree_limit ||
			    sample_dist(first_pick_y, sy) > regs_model.agree_limit) begin
				res.rejected = 1'b1;
			end else begin
				// each pick loses its low bit before the sum
				mean_x = (first_pick_x >> 1) + (sx >> 1);
				mean_y = (first_pick_y >> 1) + (sy >> 1);
				res.coord_x = calibrate_axis(mean_x, regs_model.x_gain, regs_model.x_offset);
				res.coord_y = calibrate_axis(mean_y, regs_model.y_gain, regs_model.y_offset);
			end
			coords_due.push_back(res);
		end
	endfunction

	function automatic void report_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("@%0t: %s", $time, msg);
	endfunction

	// coords side: random ready, long hold-offs on request, and the checker
	initial begin
		cal_res_t want;
		coords_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (coords_if.valid && coords_if.ready) begin
				if (coords_due.size() == 0) begin
					report_fault($sformatf("unexpected coords beat: x=%0d y=%0d rejected=%0b",
						coords_if.coord_x, coords_if.coord_y, coords_if.rejected));
				end else begin
					want = coords_due.pop_front();
					if (coords_if.coord_x !== want.coord_x || coords_if.coord_y !== want.coord_y ||
					    coords_if.rejected !== want.rejected)
						report_fault($sformatf(
							"coords mismatch: expected x=%0d y=%0d rejected=%0b, got x=%0d y=%0d rejected=%0b",
							want.coord_x, want.coord_y, want.rejected,
							coords_if.coord_x, coords_if.coord_y, coords_if.rejected));
				end
			end
			if (coords_hold != 0) begin
				coords_hold--;
				coords_if.ready <= 1'b0;
			end else begin
				coords_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// valid stays up after a beat, so back-to-back beats never drop it for a step
	task automatic send_sample(input sample_t xs, input sample_t ys);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid    <= 1'b1;
		samples_if.x_sample <= xs;
		samples_if.y_sample <= ys;
		do @(posedge clk); while (!samples_if.ready);
		cluster_filter_step(xs, ys);
	endtask

	// one burst around a center; each beat is a full-range stray with odds strays/N
	task automatic send_cluster(input int cx, input int cy, input int spread, input int strays);
		int vx;
		int vy;
		for (int i = 0; i < SAMPLES_PER_BURST; i++) begin
			vx = cx + int'($urandom_range(2 * spread)) - spread;
			vy = cy + int'($urandom_range(2 * spread)) - spread;
			if (int'($urandom_range(SAMPLES_PER_BURST - 1)) < strays) begin
				vx = $urandom_range(SAMPLE_MAX);
				vy = $urandom_range(SAMPLE_MAX);
			end
			vx = (vx < 0) ? 0 : (vx > SAMPLE_MAX) ? SAMPLE_MAX : vx;
			vy = (vy < 0) ? 0 : (vy > SAMPLE_MAX) ? SAMPLE_MAX : vy;
			send_sample(sample_t'(vx), sample_t'(vy));
		end
	endtask

	// stop sending, let every queued result out, then sit out a full scan
	task automatic wait_coords_drained();
		samples_if.valid <= 1'b0;
		while (coords_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_CLUSTER_RADIUS: regs_model.cluster_radius = value[LIMIT_BITS-1:0];
			REG_AGREE_LIMIT:    regs_model.agree_limit    = value[LIMIT_BITS-1:0];
			REG_X_GAIN:         regs_model.x_gain         = value;
			REG_X_OFFSET:       regs_model.x_offset       = value;
			REG_Y_GAIN:         regs_model.y_gain         = value;
			REG_Y_OFFSET:       regs_model.y_offset       = value;
			default: ;
		endcase
	endtask

	task automatic set_filter_cfg(input limit_t radius, input limit_t limit,
		input cal_word_t xg, input cal_word_t xo, input cal_word_t yg, input cal_word_t yo);
		wait_coords_drained();
		// junk above bit 11 of the 12-bit registers must be dropped
		write_reg(REG_CLUSTER_RADIUS, {4'($urandom), radius});
		write_reg(REG_AGREE_LIMIT, {4'($urandom), limit});
		write_reg(REG_X_GAIN, xg);
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_GAIN, yg);
		write_reg(REG_Y_OFFSET, yo);
		write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
		cfg_if.valid <= 1'b0;
	endtask

	function automatic cal_word_t random_gain();
		// mostly near unity, now and then anything the register holds
		if ($urandom_range(3) == 0)
			return cal_word_t'($urandom);
		return cal_word_t'($urandom_range(8192, 24576));
	endfunction

	function automatic cal_word_t random_offset();
		if ($urandom_range(3) == 0)
			return cal_word_t'($urandom);
		return cal_word_t'(int'($urandom_range(400)) - 200);
	endfunction

	// reset register values; also shows the low bits lost in the averaging
	task automatic test_reset_values();
		burst_t tie_x = '{2000, 4000, 4030, 20, 10, 2500, 3000, 3500, 1000, 1500};
		burst_t tie_y = '{0, 4095, 4095, 0, 700, 1400, 2100, 2800, 3500, 50};
		// 1001/1003 average to 1001, 2003/2001 to 2001
		send_cluster(1001, 2003, 0, 0);
		send_cluster(1003, 2001, 0, 0);
		// two equal clusters on X: the earlier one (4000) wins over 20/10
		for (int i = 0; i < SAMPLES_PER_BURST; i++)
			send_sample(tie_x[i], tie_y[i]);
		send_cluster(4010, 30, 5, 0);
	endtask

	// full-scale opposites: no neighbors at radius zero, and at the widest radius only equal
	// values count, since 4095 < 4095 fails; the first beat of each burst stays
	task automatic test_no_neighbors();
		for (int r = 0; r < 2; r++) begin
			set_filter_cfg(limit_t'(r ? SAMPLE_MAX : 0), '1, UNITY_GAIN, '0, UNITY_GAIN, '0);
			for (int b = 0; b < 2; b++)
				for (int i = 0; i < SAMPLES_PER_BURST; i++)
					send_sample(((i + b) % 2 != 0) ? sample_t'(0) : sample_t'(SAMPLE_MAX),
						((i + b) % 2 != 0) ? sample_t'(SAMPLE_MAX) : sample_t'(0));
			send_cluster(1000, 3000, 30, 0);
			send_cluster(1010, 2990, 30, 0);
		end
	endtask

	// agree limit: equal at the limit passes, one past it rejects
	task automatic test_agree_limit();
		set_filter_cfg(limit_t'(50), '0, UNITY_GAIN, '0, UNITY_GAIN, '0);
		send_cluster(1200, 3400, 0, 0);
		send_cluster(1200, 3400, 0, 0);
		send_cluster(1200, 3400, 0, 0);
		send_cluster(1201, 3400, 0, 0);
		set_filter_cfg(limit_t'(50), limit_t'(37), UNITY_GAIN, '0, UNITY_GAIN, '0);
		send_cluster(600, 900, 0, 0);
		send_cluster(637, 863, 0, 0);
		send_cluster(600, 900, 0, 0);
		send_cluster(637, 862, 0, 0);
	endtask

	// calibration at the register extremes, clamping, and the floor on negative slopes
	task automatic test_calibration_extremes();
		set_filter_cfg(limit_t'(50), limit_t'(50), cal_word_t'(32767), cal_word_t'(32767),
			cal_word_t'(-32768), cal_word_t'(-32768));
		send_cluster(SAMPLE_MAX, SAMPLE_MAX, 0, 0);
		send_cluster(SAMPLE_MAX, SAMPLE_MAX, 0, 0);
		// slope -1/16384 on raw 2 floors to -1; Y unclamped near the top of range
		set_filter_cfg(limit_t'(50), limit_t'(50), cal_word_t'(-1), cal_word_t'(100),
			UNITY_GAIN, cal_word_t'(32767));
		send_cluster(3, SAMPLE_MAX, 0, 0);
		send_cluster(3, SAMPLE_MAX, 0, 0);
		send_cluster(0, 0, 0, 0);
		send_cluster(0, 0, 0, 0);
	endtask

	// coords held off long enough that the output register and the next
	// pair both back up and the samples channel has to stall
	task automatic test_output_backpressure();
		set_filter_cfg(limit_t'(60), limit_t'(80), UNITY_GAIN, cal_word_t'(12), UNITY_GAIN,
			cal_word_t'(-7));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		coords_hold    = 3 * PAIR_BEATS + 4 * SETTLE_CYCLES;
		for (int p = 0; p < 3; p++) begin
			send_cluster(500 + 1000 * p, 3500 - 1000 * p, 20, 1);
			send_cluster(510 + 1000 * p, 3490 - 1000 * p, 20, 1);
		end
		wait_coords_drained();
	endtask

	// mostly burst pairs around a drifting center, with noise bursts and stray
	// beats that knock the burst boundaries off the clusters
	task automatic test_random_traffic(input int unsigned pairs, input int unsigned idle_pct,
		input int unsigned stall_pct);
		limit_t radius;
		limit_t limit;
		int     roll;
		int     cx;
		int     cy;
		int     spread;
		case ($urandom_range(5))
			0: radius = '0;
			1: radius = '1;
			default: radius = limit_t'($urandom_range(16, 200));
		endcase
		case ($urandom_range(5))
			0: limit = '0;
			1: limit = '1;
			default: limit = limit_t'($urandom_range(4, 150));
		endcase
		set_filter_cfg(radius, limit, random_gain(), random_offset(), random_gain(),
			random_offset());
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int p = 0; p < pairs; p++) begin
			roll = $urandom_range(9);
			if (roll == 0) begin
				repeat ($urandom_range(1, 7))
					send_sample(sample_t'($urandom), sample_t'($urandom));
			end else if (roll == 1) begin
				send_cluster(0, 0, 0, SAMPLES_PER_BURST);
				send_cluster(0, 0, 0, SAMPLES_PER_BURST);
			end else begin
				cx = $urandom_range(SAMPLE_MAX);
				cy = $urandom_range(SAMPLE_MAX);
				spread = $urandom_range((radius > 200) ? 200 : radius);
				send_cluster(cx, cy, spread, $urandom_range(3));
				if ($urandom_range(4) == 0) begin
					cx = $urandom_range(SAMPLE_MAX);
					cy = $urandom_range(SAMPLE_MAX);
				end else begin
					// drift straddles the agree limit on purpose
					cx += int'($urandom_range(2 * limit + 2)) - int'(limit) - 1;
					cy += int'($urandom_range(2 * limit + 2)) - int'(limit) - 1;
				end
				send_cluster(cx, cy, spread, $urandom_range(3));
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		samples_if.valid    = 1'b0;
		samples_if.x_sample = '0;
		samples_if.y_sample = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = '0;
		cfg_if.data         = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_no_neighbors();
		test_agree_limit();
		test_calibration_extremes();
		test_output_backpressure();
		test_random_traffic(21, 0, 0);
		test_random_traffic(21, 83, 0);
		test_random_traffic(21, 0, 83);
		test_random_traffic(21, 25, 25);
		wait_coords_drained();

		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
